// ----- rtl/fccw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fccw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

  localparam int TIDX_W     = 13;  // allocation table byte index
  localparam int BYTE_W     = 8;
  localparam int CLU_W      = 12;  // cluster number / count
  localparam int FBYTES_W   = 32;  // file size
  localparam int LBA_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = 33;  // divider dividend / quotient
  localparam int DIVR_W     = 13;  // divider divisor

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CLU_W-1:0] ENTRY_MASK = 12'hFFF;
  localparam logic [CLU_W-1:0] COUNT_MAX  = 12'hFFF;

  // input modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_ADV   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COPIES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SECS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_BYTE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SEC = 3'd5;

  // register reset values
  localparam logic [15:0] RST_RESERVED    = 16'd1;
  localparam logic [7:0]  RST_COPIES      = 8'd2;
  localparam logic [15:0] RST_TABLE_SECS  = 16'd9;
  localparam logic [15:0] RST_ROOT_ENTRY  = 16'd224;
  localparam logic [12:0] RST_SECTOR_BYTE = 13'd512;
  localparam logic [7:0]  RST_CLUSTER_SEC = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_ADV   = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [TIDX_W-1:0]   table_index;
    logic [BYTE_W-1:0]   table_byte;
    logic [CLU_W-1:0]    start_cluster;
    logic [FBYTES_W-1:0] file_bytes;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] reserved_sector_count;
    logic [7:0]  table_copies;
    logic [15:0] sectors_per_table;
    logic [15:0] root_entry_count;
    logic [12:0] sector_bytes;
    logic [7:0]  cluster_sectors;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/fccw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fccw_front
// Accepts input transactions, decodes the mode and drops no-op items and out-of-range table loads.
// ----------------------------------------------------------------------------
module fccw_front #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [1:0]                    in_mode,
  input  logic [fccw_pkg::TIDX_W-1:0]   in_table_index,
  input  logic [fccw_pkg::BYTE_W-1:0]   in_table_byte,
  input  logic [fccw_pkg::CLU_W-1:0]    in_start_cluster,
  input  logic [fccw_pkg::FBYTES_W-1:0] in_file_bytes,
  input  logic                          q_full,
  output logic                          q_push,
  output fccw_pkg::q_entry_t            q_entry
);
  import fccw_pkg::*;

  logic accept;
  logic keep;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    q_entry.table_index   = in_table_index;
    q_entry.table_byte    = in_table_byte;
    q_entry.start_cluster = in_start_cluster;
    q_entry.file_bytes    = in_file_bytes;
    q_entry.op            = OP_LOAD;
    keep                  = 1'b0;
    case (in_mode)
      MODE_LOAD: begin
        q_entry.op = OP_LOAD;
        // writes past the end of the table are dropped
        keep       = 32'(in_table_index) < TABLE_BYTES;
      end
      MODE_START: begin
        q_entry.op = OP_START;
        keep       = 1'b1;
      end
      MODE_ADV: begin
        q_entry.op = OP_ADV;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule
`default_nettype wire

// ----- rtl/fccw_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fccw_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fccw_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fccw_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output fccw_pkg::q_entry_t pop_data,
  output logic               empty
);
  import fccw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fccw_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fccw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fccw_div (
  input  logic               clk,
  input  logic               rst_n,
  input  fccw_pkg::div_req_t req,
  output fccw_pkg::div_rsp_t rsp
);
  import fccw_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] dsor_r;
  logic [DIV_W-1:0]  dvd_r;   // dividend shifts out, quotient shifts in
  logic [DIVR_W:0]   trial;
  logic              ge;
  logic [DIVR_W-1:0] rem_step;

  assign trial    = {rem_r, dvd_r[DIV_W-1]};
  assign ge       = trial >= {1'b0, dsor_r};
  assign rem_step = ge ? DIVR_W'(trial - {1'b0, dsor_r}) : trial[DIVR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      dvd_r  <= req.dividend;
      dsor_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;

endmodule
`default_nettype wire

// ----- rtl/fccw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fccw_back
// Walk engine: table memory, cluster count setup, chain advance, result slot.
// ----------------------------------------------------------------------------
module fccw_back #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fccw_pkg::cfg_t             cfg,
  input  logic                       cfg_touch,
  input  logic                       q_empty,
  input  fccw_pkg::q_entry_t         q_entry,
  output logic                       q_pop,
  output fccw_pkg::div_req_t         div_req,
  input  fccw_pkg::div_rsp_t         div_rsp,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [fccw_pkg::LBA_W-1:0] out_sector_lba,
  output logic [fccw_pkg::CLU_W-1:0] out_cluster_number,
  output logic                       out_last_cluster
);
  import fccw_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ROOT = 6'b000010,
    ST_BASE = 6'b000100,
    ST_SEC  = 6'b001000,
    ST_CNT  = 6'b010000,
    ST_ADV  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CLU_W-1:0]   walk_c_r, walk_c_nxt;
  logic [CLU_W-1:0]   left_r, left_nxt;
  logic [CLU_W-1:0]   start_c_r, start_c_nxt;
  logic [LBA_W-1:0]   base_r, base_nxt;
  logic               stale_r, stale_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LBA_W-1:0]   out_lba_r;
  logic [CLU_W-1:0]   out_clu_r;
  logic               out_last_r;

  logic [BYTE_W-1:0]  mem [TABLE_BYTES];
  logic [BYTE_W-1:0]  rd_lo_r, rd_hi_r;
  logic               lo_ok_r, hi_ok_r;
  logic signed [21:0] prod_r;

  logic [12:0]        bps_nz;
  logic [7:0]         spc_nz;
  logic [TIDX_W-1:0]  off, off1;
  logic signed [12:0] cm2;
  logic signed [8:0]  spc_s;
  logic signed [21:0] prod_nxt;
  logic [23:0]        fat_secs;
  logic [15:0]        pair;
  logic [CLU_W-1:0]   next_c;
  logic               slot_free;
  logic               mem_we, rd_en, out_load;

  assign bps_nz = (cfg.sector_bytes == '0) ? 13'd1 : cfg.sector_bytes;
  assign spc_nz = (cfg.cluster_sectors == '0) ? 8'd1 : cfg.cluster_sectors;

  // entry offset c + c/2 and its neighbor
  assign off  = TIDX_W'(walk_c_r) + TIDX_W'(walk_c_r[CLU_W-1:1]);
  assign off1 = off + 1'b1;

  // (c - 2) * spc, signed so clusters below two wrap as in 32-bit math
  assign cm2      = $signed({1'b0, walk_c_r}) - 13'sd2;
  assign spc_s    = $signed({1'b0, spc_nz});
  assign prod_nxt = cm2 * spc_s;

  assign fat_secs = cfg.table_copies * cfg.sectors_per_table;

  assign pair   = {hi_ok_r ? rd_hi_r : 8'd0, lo_ok_r ? rd_lo_r : 8'd0};
  assign next_c = (walk_c_r[0] ? pair[15:4] : pair[11:0]) & ENTRY_MASK;

  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt   = state_r;
    walk_c_nxt  = walk_c_r;
    left_nxt    = left_r;
    start_c_nxt = start_c_r;
    base_nxt    = base_r;
    stale_nxt   = stale_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = bps_nz;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_entry.op)
            OP_LOAD: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            OP_START: begin
              q_pop            = 1'b1;
              start_c_nxt      = q_entry.start_cluster;
              div_req.start    = 1'b1;
              div_req.dividend = {1'b0, q_entry.file_bytes} + DIV_W'(bps_nz) - 1'b1;
              div_req.divisor  = bps_nz;
              state_nxt        = ST_SEC;
            end
            OP_ADV: begin
              if (left_r == '0) begin
                q_pop = 1'b1;
              end else if (stale_r) begin
                // root directory sectors: ceil(entries * 32 / bps)
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'({cfg.root_entry_count, 5'b0}) + DIV_W'(bps_nz)
                                 - 1'b1;
                div_req.divisor  = bps_nz;
                state_nxt        = ST_ROOT;
              end else begin
                q_pop     = 1'b1;
                rd_en     = 1'b1;
                state_nxt = ST_ADV;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_ROOT: begin
        if (div_rsp.done) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        base_nxt  = LBA_W'(cfg.reserved_sector_count) + LBA_W'(fat_secs)
                  + LBA_W'(div_rsp.quot[21:0]);
        stale_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
      ST_SEC: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quot + DIV_W'(spc_nz) - 1'b1;
          div_req.divisor  = DIVR_W'(spc_nz);
          state_nxt        = ST_CNT;
        end
      end
      ST_CNT: begin
        if (div_rsp.done) begin
          left_nxt   = (|div_rsp.quot[DIV_W-1:CLU_W]) ? COUNT_MAX
                                                      : div_rsp.quot[CLU_W-1:0];
          walk_c_nxt = start_c_r;
          state_nxt  = ST_IDLE;
        end
      end
      ST_ADV: begin
        if (slot_free) begin
          out_load   = 1'b1;
          walk_c_nxt = next_c;
          left_nxt   = left_r - 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_touch) begin
      stale_nxt = 1'b1;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_c_r    <= '0;
      left_r      <= '0;
      stale_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_c_r    <= walk_c_nxt;
      left_r      <= left_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_c_r <= start_c_nxt;
    base_r    <= base_nxt;
    if (out_load) begin
      out_lba_r  <= base_r + LBA_W'(prod_r);
      out_clu_r  <= walk_c_r;
      out_last_r <= left_r == CLU_W'(1);
    end
  end

  // table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_entry.table_index)] <= q_entry.table_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_lo_r <= mem[AW'(off)];
      rd_hi_r <= mem[AW'(off1)];
      lo_ok_r <= 32'(off) < TABLE_BYTES;
      hi_ok_r <= 32'(off1) < TABLE_BYTES;
      prod_r  <= prod_nxt;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_sector_lba     = out_lba_r;
  assign out_cluster_number = out_clu_r;
  assign out_last_cluster   = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/fat12_cluster_chain_walker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker
// Walks a FAT12 cluster chain held in an on-chip allocation table copy.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  in_      | push / full         | mode, table_index, table_byte,
//           |                     | start_cluster, file_bytes
//  out_     | empty / pop         | sector_lba, cluster_number, last_cluster
//  cfg_     | valid / ready (=1)  | index, data (six geometry registers)
//
//  A table load is a single write into the table memory. An advance is a
//  registered table read of the entry byte pair, then the chain update into
//  the result register once the result slot is free. A walk start makes two
//  passes through the bit-serial divider (sectors, then clusters).
//  The first advance after reset or after any register write first rebuilds
//  the data area start with one divider pass (root directory sectors).
//  Reset clears the walk and the queues; the table memory is not cleared.
//  A full result slot stalls only the back part; the front keeps accepting
//  while the command queue has room.
//
module fat12_cluster_chain_walker #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transactions
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [1:0]                      in_mode,
  input  logic [fccw_pkg::TIDX_W-1:0]     in_table_index,
  input  logic [fccw_pkg::BYTE_W-1:0]     in_table_byte,
  input  logic [fccw_pkg::CLU_W-1:0]      in_start_cluster,
  input  logic [fccw_pkg::FBYTES_W-1:0]   in_file_bytes,
  // result transactions
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [fccw_pkg::LBA_W-1:0]      out_sector_lba,
  output logic [fccw_pkg::CLU_W-1:0]      out_cluster_number,
  output logic                            out_last_cluster,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fccw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fccw_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     cfg_we;

  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_in, q_out;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Register file. Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_RESERVED:    cfg_nxt.reserved_sector_count = cfg_data;
        REG_COPIES:      cfg_nxt.table_copies          = cfg_data[7:0];
        REG_TABLE_SECS:  cfg_nxt.sectors_per_table     = cfg_data;
        REG_ROOT_ENTRY:  cfg_nxt.root_entry_count      = cfg_data;
        REG_SECTOR_BYTE: cfg_nxt.sector_bytes          = cfg_data[12:0];
        REG_CLUSTER_SEC: cfg_nxt.cluster_sectors       = cfg_data[7:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reserved_sector_count <= RST_RESERVED;
      cfg_r.table_copies          <= RST_COPIES;
      cfg_r.sectors_per_table     <= RST_TABLE_SECS;
      cfg_r.root_entry_count      <= RST_ROOT_ENTRY;
      cfg_r.sector_bytes          <= RST_SECTOR_BYTE;
      cfg_r.cluster_sectors       <= RST_CLUSTER_SEC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode and filter
  fccw_front #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_front (
    .in_push          (in_push),
    .in_full          (in_full),
    .in_mode          (in_mode),
    .in_table_index   (in_table_index),
    .in_table_byte    (in_table_byte),
    .in_start_cluster (in_start_cluster),
    .in_file_bytes    (in_file_bytes),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in)
  );

  // command queue decouples front from back
  fccw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // shared divider for count and root directory math
  fccw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back: table memory and walk engine
  fccw_back #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cfg_touch          (cfg_we),
    .q_empty            (q_empty),
    .q_entry            (q_out),
    .q_pop              (q_pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_sector_lba     (out_sector_lba),
    .out_cluster_number (out_cluster_number),
    .out_last_cluster   (out_last_cluster)
  );

endmodule
`default_nettype wire

// ----- dv/tb_fat12_cluster_chain_walker.sv -----
// ----------------------------------------------------------------------------
// tb_fat12_cluster_chain_walker
// Self-checking bench for the FAT12 cluster chain walker. Table loads, walk
// starts and advances are planned into a backlog that a clocked driver
// pushes. Each accepted transaction is run through a bench-side walk
// predictor. A clocked monitor pops the results at random and compares every
// field against the oldest predicted cluster report. Geometry registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_fat12_cluster_chain_walker;
  timeunit 1ns;
  timeprecision 1ps;

  import fccw_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;  // spare encoding, block ignores it
  localparam int TBL_DEPTH    = 8192;
  localparam int QUIET_CYCLES = 300;       // covers a start plus a base rebuild
  localparam int HOLD_CYCLES  = 400;       // long pop hold-off, fills the queues
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic [1:0]          mode;
    logic [TIDX_W-1:0]   tidx;
    logic [BYTE_W-1:0]   tbyte;
    logic [CLU_W-1:0]    first;
    logic [FBYTES_W-1:0] fbytes;
  } walk_cmd_t;

  typedef struct packed {
    logic [LBA_W-1:0] lba;
    logic [CLU_W-1:0] clu;
    logic             last;
  } cluster_report_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [1:0]            in_mode = '0;
  logic [TIDX_W-1:0]     in_table_index = '0;
  logic [BYTE_W-1:0]     in_table_byte = '0;
  logic [CLU_W-1:0]      in_start_cluster = '0;
  logic [FBYTES_W-1:0]   in_file_bytes = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [LBA_W-1:0]      out_sector_lba;
  logic [CLU_W-1:0]      out_cluster_number;
  logic                  out_last_cluster;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fat12_cluster_chain_walker #(
    .TABLE_BYTES(TBL_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_mode           (in_mode),
    .in_table_index    (in_table_index),
    .in_table_byte     (in_table_byte),
    .in_start_cluster  (in_start_cluster),
    .in_file_bytes     (in_file_bytes),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_sector_lba    (out_sector_lba),
    .out_cluster_number(out_cluster_number),
    .out_last_cluster  (out_last_cluster),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: geometry, table copy, walk position
  // --------------------------------------------------------------------------
  cfg_t              geom;
  logic [7:0]        tbl_mem [TBL_DEPTH];
  logic [CLU_W-1:0]  walk_at = '0;
  logic [CLU_W-1:0]  walk_left = '0;   // zero means no walk in progress
  cluster_report_t   lba_reports [$];  // predicted, not yet popped

  // Planner state: tracks what the table will hold once the backlog has been
  // pushed, so that an advance never reads a byte nobody wrote.
  logic [7:0]        plan_tbl [TBL_DEPTH];
  bit                plan_known [TBL_DEPTH];
  logic [CLU_W-1:0]  plan_at = '0;
  logic [CLU_W-1:0]  plan_left = '0;
  walk_cmd_t         cmd_backlog [$];
  int                cmds_planned = 0;

  int                mismatches = 0;
  int                results_seen = 0;
  int                cyc = 0;
  bit                held = 1'b0;
  int                hold_left = 0;

  always @(posedge clk) cyc <= cyc + 1;

  // --------------------------------------------------------------------------
  // Walk arithmetic
  // --------------------------------------------------------------------------
  // zero sector size or cluster size behaves as one
  function automatic logic [31:0] at_least_one(logic [31:0] v);
    return (v == 0) ? 32'd1 : v;
  endfunction

  // ceil(ceil(bytes / sector) / cluster), saturated at the 12-bit maximum
  function automatic logic [CLU_W-1:0] clusters_for(logic [FBYTES_W-1:0] nbytes);
    logic [63:0] bps;
    logic [63:0] spc;
    logic [63:0] secs;
    logic [63:0] cnt;
    bps  = 64'(at_least_one(32'(geom.sector_bytes)));
    spc  = 64'(at_least_one(32'(geom.cluster_sectors)));
    secs = (64'(nbytes) + bps - 1) / bps;
    cnt  = (secs + spc - 1) / spc;
    return (cnt > 64'(COUNT_MAX)) ? COUNT_MAX : cnt[CLU_W-1:0];
  endfunction

  // data area start plus (cluster - 2) clusters; clusters 0 and 1 wrap
  function automatic logic [LBA_W-1:0] first_sector(logic [CLU_W-1:0] c);
    logic [31:0] bps;
    logic [31:0] root;
    logic [31:0] base;
    bps  = at_least_one(32'(geom.sector_bytes));
    root = (32'(geom.root_entry_count) * 32'd32 + bps - 1) / bps;
    base = 32'(geom.reserved_sector_count)
         + 32'(geom.table_copies) * 32'(geom.sectors_per_table) + root;
    return base + (32'(c) - 32'd2) * at_least_one(32'(geom.cluster_sectors));
  endfunction

  // 12-bit entries are packed: entry c starts at byte c + c/2
  function automatic logic [TIDX_W-1:0] entry_offset(logic [CLU_W-1:0] c);
    return TIDX_W'(c) + TIDX_W'(c >> 1);
  endfunction

  // even clusters take the low 12 bits of the byte pair, odd ones the high 12
  function automatic logic [CLU_W-1:0] unpack_entry(logic [CLU_W-1:0] c,
                                                    logic [7:0] lo, logic [7:0] hi);
    logic [15:0] pair;
    pair = {hi, lo};
    return c[0] ? pair[15:4] : pair[11:0];
  endfunction

  // Runs one accepted transaction through the bench copy of the walk.
  task automatic predict_cluster_report(walk_cmd_t cmd);
    cluster_report_t rep;
    logic [TIDX_W-1:0] off;
    case (cmd.mode)
      MODE_LOAD: begin
        tbl_mem[cmd.tidx] = cmd.tbyte;
      end
      MODE_START: begin
        // a new start simply replaces any walk in progress
        walk_at   = cmd.first;
        walk_left = clusters_for(cmd.fbytes);
      end
      MODE_ADV: begin
        if (walk_left != 0) begin
          rep.lba  = first_sector(walk_at);
          rep.clu  = walk_at;
          rep.last = (walk_left == 1);
          lba_reports.push_back(rep);
          off       = entry_offset(walk_at);
          walk_at   = unpack_entry(walk_at, tbl_mem[off], tbl_mem[off + 1]);
          walk_left = walk_left - 1'b1;
        end
      end
      default: ;  // spare mode: nothing happens
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Planning: queues a transaction and keeps the planner's view current.
  // Before an advance of a live walk, any missing entry byte is loaded first
  // with random content, so chains wander over the whole table.
  // Field values come in 32 bits wide and are cut to the field widths here.
  // --------------------------------------------------------------------------
  task automatic plan_cmd(logic [1:0] mode, logic [31:0] idx,
                          logic [31:0] byt, logic [31:0] first,
                          logic [31:0] nbytes);
    walk_cmd_t cmd;
    logic [TIDX_W-1:0] off;
    int k;
    cmd = '{mode, TIDX_W'(idx), BYTE_W'(byt), CLU_W'(first), FBYTES_W'(nbytes)};
    if (mode == MODE_LOAD) begin
      plan_tbl[cmd.tidx]   = cmd.tbyte;
      plan_known[cmd.tidx] = 1'b1;
    end else if (mode == MODE_START) begin
      plan_at   = cmd.first;
      plan_left = clusters_for(cmd.fbytes);
    end else if (mode == MODE_ADV && plan_left != 0) begin
      off = entry_offset(plan_at);
      for (k = 0; k < 2; k++) begin
        if (!plan_known[off + k])
          plan_cmd(MODE_LOAD, 32'(off) + 32'(k), $urandom, $urandom, $urandom);
      end
      plan_at   = unpack_entry(plan_at, plan_tbl[off], plan_tbl[off + 1]);
      plan_left = plan_left - 1'b1;
    end
    cmd_backlog.push_back(cmd);
    cmds_planned++;
  endtask

  // file size that yields exactly n clusters under the current geometry
  function automatic logic [FBYTES_W-1:0] bytes_for(int n);
    int units;
    units = at_least_one(32'(geom.sector_bytes)) * at_least_one(32'(geom.cluster_sectors));
    return $urandom_range(n * units, (n - 1) * units + 1);
  endfunction

  // Mostly complete walks with random content; the rest is noise: stray
  // loads, oversized files, empty files, spare modes, lone advances.
  task automatic random_phase(int n);
    int stop;
    int r;
    int cnt;
    int steps;
    stop = cmds_planned + n;
    while (cmds_planned < stop) begin
      r = $urandom_range(99);
      if (r < 70) begin
        cnt   = $urandom_range(6, 1);
        steps = cnt;
        r     = $urandom_range(9);
        if (r == 0)
          steps = cnt - 1;      // cut short, next start overrides
        else if (r < 3)
          steps = cnt + 1;      // one advance past the end
        plan_cmd(MODE_START, $urandom, $urandom, $urandom, bytes_for(cnt));
        repeat (steps) plan_cmd(MODE_ADV, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 80) begin
        plan_cmd(MODE_LOAD, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 87) begin
        plan_cmd(MODE_START, $urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(4, 1))
          plan_cmd(MODE_ADV, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 92) begin
        plan_cmd(MODE_START, $urandom, $urandom, $urandom, '0);
      end else if (r < 96) begin
        plan_cmd(MODE_NOP, $urandom, $urandom, $urandom, $urandom);
      end else begin
        plan_cmd(MODE_ADV, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Idling: ~20% gaps on both sides, none inside a fixed window of cycles
  // --------------------------------------------------------------------------
  function automatic bit take_break();
    return !(cyc >= 1500 && cyc < 4500) && ($urandom_range(99) < 20);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: a transaction stays on the bus until the block takes it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full)
        predict_cluster_report(cmd_backlog.pop_front());
      if (!(in_push && in_full)) begin
        if (cmd_backlog.size() != 0 && !take_break()) begin
          in_push          <= 1'b1;
          in_mode          <= cmd_backlog[0].mode;
          in_table_index   <= cmd_backlog[0].tidx;
          in_table_byte    <= cmd_backlog[0].tbyte;
          in_start_cluster <= cmd_backlog[0].first;
          in_file_bytes    <= cmd_backlog[0].fbytes;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and checker
  // --------------------------------------------------------------------------
  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic check_report();
    cluster_report_t want;
    results_seen++;
    if (lba_reports.size() == 0) begin
      flag("unpredicted result, cluster", '0, 32'(out_cluster_number));
    end else begin
      want = lba_reports.pop_front();
      if (out_sector_lba !== want.lba)
        flag("sector_lba", want.lba, out_sector_lba);
      if (out_cluster_number !== want.clu)
        flag("cluster_number", 32'(want.clu), 32'(out_cluster_number));
      if (out_last_cluster !== want.last)
        flag("last_cluster", 32'(want.last), 32'(out_last_cluster));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty)
        check_report();
      // one long hold-off while the driver still has plenty queued, so the
      // result slot and the command queue fill and in_full asserts
      if (!held && results_seen > 30 && cmd_backlog.size() > 20) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= !take_break();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register writes, only while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RESERVED:    geom.reserved_sector_count = data;
      REG_COPIES:      geom.table_copies          = data[7:0];
      REG_TABLE_SECS:  geom.sectors_per_table     = data;
      REG_ROOT_ENTRY:  geom.root_entry_count      = data;
      REG_SECTOR_BYTE: geom.sector_bytes          = data[12:0];
      REG_CLUSTER_SEC: geom.cluster_sectors       = data[7:0];
      default: ;
    endcase
  endtask

  task automatic write_geom(int reserved, int copies, int table_secs,
                            int root, int sec_bytes, int clu_secs);
    write_reg(REG_RESERVED, CFG_DATA_W'(reserved));
    write_reg(REG_COPIES, CFG_DATA_W'(copies));
    write_reg(REG_TABLE_SECS, CFG_DATA_W'(table_secs));
    write_reg(REG_ROOT_ENTRY, CFG_DATA_W'(root));
    write_reg(REG_SECTOR_BYTE, CFG_DATA_W'(sec_bytes));
    write_reg(REG_CLUSTER_SEC, CFG_DATA_W'(clu_secs));
    cfg_valid <= 1'b0;
  endtask

  // backlog pushed, all results popped, then quiet time for trailing work
  task automatic settle();
    while (cmd_backlog.size() != 0 || lba_reports.size() != 0 || in_push)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    geom = '{RST_RESERVED, RST_COPIES, RST_TABLE_SECS, RST_ROOT_ENTRY,
             RST_SECTOR_BYTE, RST_CLUSTER_SEC};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset geometry (512-byte sectors, one sector per cluster)
    plan_cmd(MODE_LOAD, '0, 32'h00, '0, '0);
    plan_cmd(MODE_LOAD, 32'h1FFF, 32'hFF, '0, '0);
    plan_cmd(MODE_LOAD, 32'h1555, 32'hAA, '0, '0);
    plan_cmd(MODE_LOAD, 32'h0AAA, 32'h55, '0, '0);
    plan_cmd(MODE_ADV, '0, '0, '0, '0);               // advance with no walk
    plan_cmd(MODE_NOP, '1, '1, '1, '1);               // spare mode
    plan_cmd(MODE_START, '0, '0, '0, '0);             // empty file stays idle
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_START, '0, '0, 32'd0, 32'd1);       // cluster 0: address wraps
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_START, '0, '0, 32'd1, 32'd1024);    // cluster 1, two clusters
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_START, '0, '0, 32'hFFF, 32'hFFFF_FFFF);  // count saturates
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_START, '0, '0, 32'h555, 32'd600);
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_START, '0, '0, 32'hAAA, 32'd512);   // restart mid-walk
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    plan_cmd(MODE_ADV, '0, '0, '0, '0);
    settle();

    // largest geometry
    write_geom(16'hFFFF, 255, 16'hFFFF, 16'hFFFF, 4096, 128);
    random_phase(120);
    settle();

    // smallest geometry
    write_geom(0, 1, 1, 0, 128, 1);
    random_phase(120);
    settle();

    // zero sector and cluster sizes, taken as one
    write_geom($urandom, $urandom_range(255, 1), $urandom_range(65535, 1),
               $urandom, 0, 0);
    random_phase(60);
    settle();

    repeat (2) begin
      write_geom($urandom, $urandom_range(255, 1), $urandom_range(65535, 1),
                 $urandom, 128 << $urandom_range(5), 1 << $urandom_range(7));
      random_phase(100);
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
